// ===== hw/rtl/tli_pkg.sv =====
// ---------------------------------------------------------------------------
// tli_pkg
// shared types and constants of the table interpolator
// ---------------------------------------------------------------------------
package tli_pkg;

  localparam int unsigned MaxRowsDefault = 256;
  localparam int unsigned DataW = 32;
  localparam int unsigned CountW = 9;
  localparam int unsigned IdxW = 8;
  localparam int unsigned FracW = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MREAD,
    ST_MSCAN,
    ST_VREAD,
    ST_VSCAN,
    ST_DIV,
    ST_MUL,
    ST_DONE,
    ST_OUT
  } state_t;

  // which lookup is being worked
  typedef enum logic [1:0] {
    LK_LMOI,
    LK_RMOI,
    LK_CG,
    LK_CP
  } lookup_t;

  typedef struct packed {
    logic start;
    logic [DataW:0] num;
    logic [DataW:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [FracW-1:0] quo;
  } div_rsp_t;

endpackage

// ===== hw/rtl/tli_divider.sv =====
// ---------------------------------------------------------------------------
// tli_divider
// restoring divider, one quotient bit per cycle, fraction (num<<16)/den
// ---------------------------------------------------------------------------
module tli_divider (
  input  logic             clk,
  input  logic             rst_n,
  input  tli_pkg::div_req_t req,
  output tli_pkg::div_rsp_t rsp
);

  localparam int unsigned W = tli_pkg::DataW + 1;
  localparam int unsigned FW = tli_pkg::FracW;
  localparam int unsigned CntW = $clog2(FW + 1);

  logic [W:0]          rem_r, rem_nxt;
  logic [W-1:0]        den_r, den_nxt;
  logic [FW-1:0]       quo_r, quo_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [W:0]          shifted;

  // num < den always, so remainder stays below den
  always_comb begin
    rem_nxt = rem_r;
    den_nxt = den_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted = {rem_r[W-1:0], 1'b0};
    if (req.start) begin
      rem_nxt = {1'b0, req.num};
      den_nxt = req.den;
      cnt_nxt = CntW'(FW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = shifted - {1'b0, den_r};
        quo_nxt = {quo_r[FW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[FW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo = quo_r;

endmodule

// ===== hw/rtl/tli_table_ram.sv =====
// ---------------------------------------------------------------------------
// tli_table_ram
// row store, one write port and one registered read port
// ---------------------------------------------------------------------------
module tli_table_ram #(
  parameter int unsigned Depth = tli_pkg::MaxRowsDefault,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned RowW = 6 * tli_pkg::DataW
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [RowW-1:0]  wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [RowW-1:0]  rdata
);

  logic [RowW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/table_linear_interpolator_top.sv =====
// ---------------------------------------------------------------------------
// table_linear_interpolator_top
// piecewise linear lookup over a loaded table of rows
// ---------------------------------------------------------------------------
// usage:
//   in_* transaction with in_kind 0 writes one table row, no result; in_ready
//   stays high, so row writes can follow back to back.
//   in_* transaction with in_kind 1 runs a query and one out_* transaction
//   follows; in_ready is low until that result is taken.
//   cfg_* transaction sets rows_in_use; rows_in_use must be written only while
//   the block is idle, which the block itself does not enforce. a query reads
//   one row per MREAD/MSCAN state pair through the single ram read port,
//   checks the mass and velocity columns on the same read and stops once both
//   have hit; a mass interpolation then runs the divider and 3 multiply steps,
//   a velocity one a divider start, the divider and a multiply step. an empty
//   table answers on the next cycle. the result waits in out_* registers while
//   out_ready is low. reset clears the sequencer and rows_in_use; table
//   contents are undefined until written.
// ---------------------------------------------------------------------------
module table_linear_interpolator_top #(
  parameter int unsigned MaxRows = tli_pkg::MaxRowsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_rows_in_use,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_row_index,
  input  logic signed [31:0] in_velocity,
  input  logic signed [31:0] in_mass,
  input  logic signed [31:0] in_long_moi,
  input  logic signed [31:0] in_radial_moi,
  input  logic signed [31:0] in_cg_pos,
  input  logic signed [31:0] in_cp_pos,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_long_moi_out,
  output logic signed [31:0] out_radial_moi_out,
  output logic signed [31:0] out_cg_out,
  output logic signed [31:0] out_cp_out,
  output logic        out_table_empty
);

  localparam int unsigned DW = tli_pkg::DataW;
  localparam int unsigned AW = $clog2(MaxRows);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned RowW = 6 * DW;

  tli_pkg::state_t state_r, state_nxt;
  tli_pkg::lookup_t lk_r, lk_nxt;

  logic [tli_pkg::CountW-1:0] rows_r;
  logic [NW-1:0]   n_r, n_nxt;          // clamped row count
  logic [NW-1:0]   i_r, i_nxt;          // scan row index
  logic signed [DW-1:0] qmass_r, qvel_r;
  logic signed [DW-1:0] kp_r, kp_nxt;   // previous key
  logic [4*DW-1:0] vp_r, vp_nxt;        // previous row values (lmoi rmoi cg cp)
  // found state per column: 0 pending, then use row directly or interpolate
  logic            mhit_r, mhit_nxt, minterp_r, minterp_nxt;
  logic            vhit_r, vhit_nxt, vinterp_r, vinterp_nxt;
  logic [DW:0]     mnum_r, mnum_nxt, mden_r, mden_nxt;
  logic [DW:0]     vnum_r, vnum_nxt, vden_r, vden_nxt;
  logic [3*DW-1:0] mv0_r, mv0_nxt, mv1_r, mv1_nxt;
  logic [DW-1:0]   vv0_r, vv0_nxt, vv1_r, vv1_nxt;
  logic [tli_pkg::FracW-1:0] alpha_r, alpha_nxt;
  logic signed [DW-1:0] res_r [4];
  logic signed [DW-1:0] res_nxt [4];
  logic            empty_r, empty_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_raddr;
  logic [RowW-1:0] ram_wdata, ram_rdata;
  tli_pkg::div_req_t div_req;
  tli_pkg::div_rsp_t div_rsp;

  logic signed [DW-1:0] rk_mass, rk_vel;
  logic [4*DW-1:0] rvals;
  logic signed [DW-1:0] cur_v0, cur_v1;
  logic signed [DW:0]   vdiff;
  logic signed [DW+tli_pkg::FracW+1:0] prod;
  logic signed [DW+1:0] delta, sum;
  logic signed [DW-1:0] sat;
  logic accept_in, last_row;

  assign accept_in = in_valid && in_ready;
  assign in_ready = (state_r == tli_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign ram_we = accept_in && !in_kind && (32'(in_row_index) < MaxRows);
  assign ram_wdata = {in_velocity, in_mass, in_long_moi, in_radial_moi,
                      in_cg_pos, in_cp_pos};

  tli_table_ram #(.Depth(MaxRows), .AddrW(AW), .RowW(RowW)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_row_index)),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tli_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // row unpack: vel mass lmoi rmoi cg cp
  assign rk_vel  = ram_rdata[6*DW-1 -: DW];
  assign rk_mass = ram_rdata[5*DW-1 -: DW];
  assign rvals   = ram_rdata[4*DW-1:0];
  assign last_row = (i_r == n_r - 1'b1);
  assign ram_raddr = i_r[AW-1:0];

  // current interpolation operands
  always_comb begin
    case (lk_r)
      tli_pkg::LK_LMOI: begin
        cur_v0 = mv0_r[3*DW-1 -: DW];
        cur_v1 = mv1_r[3*DW-1 -: DW];
      end
      tli_pkg::LK_RMOI: begin
        cur_v0 = mv0_r[2*DW-1 -: DW];
        cur_v1 = mv1_r[2*DW-1 -: DW];
      end
      tli_pkg::LK_CG: begin
        cur_v0 = mv0_r[DW-1:0];
        cur_v1 = mv1_r[DW-1:0];
      end
      default: begin
        cur_v0 = vv0_r;
        cur_v1 = vv1_r;
      end
    endcase
    vdiff = {cur_v1[DW-1], cur_v1} - {cur_v0[DW-1], cur_v0};
    prod = vdiff * $signed({1'b0, alpha_r});
    // arithmetic shift floors toward minus infinity
    delta = (DW+2)'(prod >>> tli_pkg::FracW);
    sum = {{2{cur_v0[DW-1]}}, cur_v0} + delta;
    if (sum > $signed({3'b000, {(DW-1){1'b1}}})) sat = {1'b0, {(DW-1){1'b1}}};
    else if (sum < $signed({3'b111, {(DW-1){1'b0}}})) sat = {1'b1, {(DW-1){1'b0}}};
    else sat = sum[DW-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tli_pkg::ST_IDLE: begin
        if (accept_in && in_kind) begin
          state_nxt = (rows_r == '0) ? tli_pkg::ST_OUT : tli_pkg::ST_MREAD;
        end
      end
      tli_pkg::ST_MREAD: state_nxt = tli_pkg::ST_MSCAN;
      tli_pkg::ST_MSCAN: begin
        if (mhit_nxt && vhit_nxt) state_nxt = tli_pkg::ST_DONE;
        else if (last_row) state_nxt = tli_pkg::ST_DONE;
        else state_nxt = tli_pkg::ST_MREAD;
      end
      tli_pkg::ST_DONE: begin
        if (lk_r == tli_pkg::LK_CP) state_nxt = tli_pkg::ST_OUT;
        else if (lk_r == tli_pkg::LK_LMOI && !minterp_r && !vinterp_r)
          state_nxt = tli_pkg::ST_OUT;
        else if ((lk_r == tli_pkg::LK_LMOI && minterp_r)) state_nxt = tli_pkg::ST_DIV;
        else if (lk_r == tli_pkg::LK_LMOI) state_nxt = tli_pkg::ST_VREAD;
        else state_nxt = tli_pkg::ST_OUT;
      end
      tli_pkg::ST_VREAD: state_nxt = tli_pkg::ST_DIV;
      tli_pkg::ST_DIV: begin
        if (div_rsp.done) state_nxt = tli_pkg::ST_MUL;
      end
      tli_pkg::ST_MUL: begin
        // mass alpha reused for all three moments, so stay here for them
        if (lk_r == tli_pkg::LK_CG) begin
          state_nxt = vinterp_r ? tli_pkg::ST_VSCAN : tli_pkg::ST_OUT;
        end else if (lk_r == tli_pkg::LK_CP) begin
          state_nxt = tli_pkg::ST_OUT;
        end
      end
      tli_pkg::ST_VSCAN: state_nxt = tli_pkg::ST_DIV;
      tli_pkg::ST_OUT: begin
        if (out_valid_r && out_ready) state_nxt = tli_pkg::ST_IDLE;
      end
      default: state_nxt = tli_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    logic signed [DW-1:0] k;
    logic [4*DW-1:0] v;
    lk_nxt = lk_r;
    n_nxt = n_r;
    i_nxt = i_r;
    kp_nxt = kp_r;
    vp_nxt = vp_r;
    mhit_nxt = mhit_r;
    minterp_nxt = minterp_r;
    vhit_nxt = vhit_r;
    vinterp_nxt = vinterp_r;
    mnum_nxt = mnum_r;
    mden_nxt = mden_r;
    vnum_nxt = vnum_r;
    vden_nxt = vden_r;
    mv0_nxt = mv0_r;
    mv1_nxt = mv1_r;
    vv0_nxt = vv0_r;
    vv1_nxt = vv1_r;
    alpha_nxt = alpha_r;
    res_nxt = res_r;
    empty_nxt = empty_r;
    out_valid_nxt = out_valid_r;
    div_req = '0;
    k = '0;
    v = '0;
    case (state_r)
      tli_pkg::ST_IDLE: begin
        if (accept_in && in_kind) begin
          if (32'(rows_r) > MaxRows) n_nxt = NW'(MaxRows);
          else n_nxt = NW'(rows_r);
          i_nxt = '0;
          mhit_nxt = 1'b0;
          minterp_nxt = 1'b0;
          vhit_nxt = 1'b0;
          vinterp_nxt = 1'b0;
          lk_nxt = tli_pkg::LK_LMOI;
          empty_nxt = (rows_r == '0);
          for (int c = 0; c < 4; c++) res_nxt[c] = '0;
          out_valid_nxt = (rows_r == '0);
        end
      end
      tli_pkg::ST_MSCAN: begin
        // one row per MREAD/MSCAN pass: both columns checked on the same read
        v = rvals;
        // mass column
        k = rk_mass;
        if (!mhit_r) begin
          if ((i_r == '0) ? (qmass_r <= k) : (qmass_r == k)) begin
            mhit_nxt = 1'b1;
            mv0_nxt = v[4*DW-1:DW];
          end else if (i_r != '0 && qmass_r > kp_r && qmass_r < k) begin
            mhit_nxt = 1'b1;
            minterp_nxt = 1'b1;
            mnum_nxt = {qmass_r[DW-1], qmass_r} - {kp_r[DW-1], kp_r};
            mden_nxt = {k[DW-1], k} - {kp_r[DW-1], kp_r};
            mv0_nxt = vp_r[4*DW-1:DW];
            mv1_nxt = v[4*DW-1:DW];
          end else if (last_row) begin
            mhit_nxt = 1'b1;
            mv0_nxt = v[4*DW-1:DW];
          end
        end
        // velocity column, previous key kept in vnum until the column hits
        k = rk_vel;
        if (!vhit_r) begin
          if ((i_r == '0) ? (qvel_r <= k) : (qvel_r == k)) begin
            vhit_nxt = 1'b1;
            vv0_nxt = v[DW-1:0];
          end else if (i_r != '0 && qvel_r > $signed(vnum_r[DW-1:0]) && qvel_r < k) begin
            vhit_nxt = 1'b1;
            vinterp_nxt = 1'b1;
            vden_nxt = {k[DW-1], k} - {vnum_r[DW-1], vnum_r[DW-1:0]};
            vnum_nxt = {qvel_r[DW-1], qvel_r} - {vnum_r[DW-1], vnum_r[DW-1:0]};
            vv0_nxt = vp_r[DW-1:0];
            vv1_nxt = v[DW-1:0];
          end else if (last_row) begin
            vhit_nxt = 1'b1;
            vv0_nxt = v[DW-1:0];
          end
        end
        if (!(vhit_nxt && !vhit_r) && !vhit_r) vnum_nxt = {rk_vel[DW-1], rk_vel};
        kp_nxt = rk_mass;
        vp_nxt = v;
        i_nxt = i_r + 1'b1;
      end
      tli_pkg::ST_DONE: begin
        // direct values first, interpolations overwrite later
        res_nxt[0] = mv0_r[3*DW-1 -: DW];
        res_nxt[1] = mv0_r[2*DW-1 -: DW];
        res_nxt[2] = mv0_r[DW-1:0];
        res_nxt[3] = vv0_r;
        if (lk_r == tli_pkg::LK_LMOI && !minterp_r && !vinterp_r) out_valid_nxt = 1'b1;
        if (lk_r == tli_pkg::LK_LMOI && minterp_r) begin
          div_req.start = 1'b1;
          div_req.num = mnum_r;
          div_req.den = mden_r;
        end
        if (lk_r == tli_pkg::LK_LMOI && !minterp_r) lk_nxt = tli_pkg::LK_CP;
      end
      tli_pkg::ST_VREAD: begin
        div_req.start = 1'b1;
        div_req.num = vnum_r;
        div_req.den = vden_r;
      end
      tli_pkg::ST_DIV: begin
        if (div_rsp.done) alpha_nxt = div_rsp.quo;
      end
      tli_pkg::ST_MUL: begin
        case (lk_r)
          tli_pkg::LK_LMOI: begin res_nxt[0] = sat; lk_nxt = tli_pkg::LK_RMOI; end
          tli_pkg::LK_RMOI: begin res_nxt[1] = sat; lk_nxt = tli_pkg::LK_CG; end
          tli_pkg::LK_CG: begin
            res_nxt[2] = sat;
            lk_nxt = tli_pkg::LK_CP;
            if (!vinterp_r) out_valid_nxt = 1'b1;
          end
          default: begin res_nxt[3] = sat; out_valid_nxt = 1'b1; end
        endcase
      end
      tli_pkg::ST_VSCAN: begin
        div_req.start = 1'b1;
        div_req.num = vnum_r;
        div_req.den = vden_r;
      end
      tli_pkg::ST_OUT: begin
        if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tli_pkg::ST_IDLE;
      rows_r <= '0;
      out_valid_r <= 1'b0;
      lk_r <= tli_pkg::LK_LMOI;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) rows_r <= cfg_rows_in_use;
      out_valid_r <= out_valid_nxt;
      lk_r <= lk_nxt;
    end
    n_r <= n_nxt;
    i_r <= i_nxt;
    kp_r <= kp_nxt;
    vp_r <= vp_nxt;
    mhit_r <= mhit_nxt;
    minterp_r <= minterp_nxt;
    vhit_r <= vhit_nxt;
    vinterp_r <= vinterp_nxt;
    mnum_r <= mnum_nxt;
    mden_r <= mden_nxt;
    vnum_r <= vnum_nxt;
    vden_r <= vden_nxt;
    mv0_r <= mv0_nxt;
    mv1_r <= mv1_nxt;
    vv0_r <= vv0_nxt;
    vv1_r <= vv1_nxt;
    alpha_r <= alpha_nxt;
    res_r <= res_nxt;
    empty_r <= empty_nxt;
    if (accept_in && in_kind) begin
      qmass_r <= in_mass;
      qvel_r <= in_velocity;
    end
  end

  assign out_valid = out_valid_r;
  assign out_long_moi_out = res_r[0];
  assign out_radial_moi_out = res_r[1];
  assign out_cg_out = res_r[2];
  assign out_cp_out = res_r[3];
  assign out_table_empty = empty_r;

endmodule

// ===== hw/rtl/tli_checker.sv =====
// ---------------------------------------------------------------------------
// tli_checker
// port-level checks of the table interpolator
// ---------------------------------------------------------------------------
module tli_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_kind,
  input logic out_valid,
  input logic out_ready,
  input logic out_table_empty,
  input logic signed [31:0] out_long_moi_out,
  input logic signed [31:0] out_cp_out
);

  // a pending result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_long_moi_out)
                                && $stable(out_cp_out))
    else $error("result changed while stalled");

  // no input taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready with result pending");

  // an empty table reports zero long moi and cp values
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_empty |-> out_long_moi_out == 0 && out_cp_out == 0)
    else $error("empty result not zero");

  // a query drops ready on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind |=> !in_ready)
    else $error("ready stayed high after query");

endmodule

bind table_linear_interpolator_top tli_checker u_tli_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_kind        (in_kind),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_table_empty(out_table_empty),
  .out_long_moi_out(out_long_moi_out),
  .out_cp_out     (out_cp_out)
);

// ===== sim/tb_table_linear_interpolator_top.sv =====
// ---------------------------------------------------------------------------
// tb_table_linear_interpolator_top
// self-checking bench: row writes and queries against a local interpolation
// model, random idling on both channels, rows_in_use swept between phases
// ---------------------------------------------------------------------------
module tb_table_linear_interpolator_top;

  // one input transaction
  typedef struct {
    logic               kind;
    logic [7:0]         row_index;
    logic signed [31:0] velocity;
    logic signed [31:0] mass;
    logic signed [31:0] long_moi;
    logic signed [31:0] radial_moi;
    logic signed [31:0] cg_pos;
    logic signed [31:0] cp_pos;
  } row_item_t;

  // one result transaction
  typedef struct {
    logic signed [31:0] long_moi;
    logic signed [31:0] radial_moi;
    logic signed [31:0] cg;
    logic signed [31:0] cp;
    logic               empty;
  } lookup_result_t;

  localparam int KVel  = 0;
  localparam int KMass = 1;
  localparam int KLmoi = 2;
  localparam int KRmoi = 3;
  localparam int KCg   = 4;
  localparam int KCp   = 5;
  localparam int StallLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [8:0] cfg_rows_in_use = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [7:0] in_row_index = '0;
  logic signed [31:0] in_velocity = '0, in_mass = '0, in_long_moi = '0;
  logic signed [31:0] in_radial_moi = '0, in_cg_pos = '0, in_cp_pos = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_long_moi_out, out_radial_moi_out, out_cg_out, out_cp_out;
  logic out_table_empty;

  table_linear_interpolator_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state: the table and the row count as the predictor sees them
  logic signed [31:0] model_table [256][6];
  int unsigned        model_rows;

  row_item_t      pending_items [$];
  lookup_result_t expected_results [$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  timed_out = 1'b0;
  bit  hold_off = 1'b0;
  int  cfg_target = -1;

  // append one item to the driver queue
  task automatic enqueue(row_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // linear interpolation between two bracketing rows, saturated
  function automatic logic signed [31:0] blend(longint k0, longint k1, longint key,
                                               longint v0, longint v1);
    longint unsigned num, den;
    longint alpha, prod, delta, sum;
    num = longint'(key - k0);
    den = longint'(k1 - k0);
    alpha = longint'((num << 16) / den);
    prod = (v1 - v0) * alpha;
    if (prod >= 0) delta = prod >>> 16;
    else delta = -((-prod + 65535) >>> 16);
    sum = v0 + delta;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  // scan one key column and return the matching or interpolated value
  function automatic logic signed [31:0] scan_column(int unsigned n, int kc, int vc,
                                                     longint key);
    longint kp, kn;
    if (key <= longint'(model_table[0][kc])) return model_table[0][vc];
    for (int i = 1; i < n; i++) begin
      kp = model_table[i-1][kc];
      kn = model_table[i][kc];
      if (key == kn) return model_table[i][vc];
      if (key > kp && key < kn)
        return blend(kp, kn, key, model_table[i-1][vc], model_table[i][vc]);
    end
    return model_table[n-1][vc];
  endfunction

  // update the table or work out the query answer
  function automatic void predict_lookup(row_item_t it);
    lookup_result_t r;
    int unsigned n;
    if (!it.kind) begin
      model_table[it.row_index] = '{it.velocity, it.mass, it.long_moi,
                                    it.radial_moi, it.cg_pos, it.cp_pos};
      return;
    end
    n = (model_rows > 256) ? 256 : model_rows;
    r = '{default: '0};
    if (n == 0) r.empty = 1'b1;
    else begin
      r.long_moi   = scan_column(n, KMass, KLmoi, it.mass);
      r.radial_moi = scan_column(n, KMass, KRmoi, it.mass);
      r.cg         = scan_column(n, KMass, KCg, it.mass);
      r.cp         = scan_column(n, KVel, KCp, it.velocity);
    end
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  // driver: offers pending items, random gaps between transactions
  int drive_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_lookup('{in_kind, in_row_index, in_velocity, in_mass, in_long_moi,
                         in_radial_moi, in_cg_pos, in_cp_pos});
        drive_gap <= short_gap();
      end
      if (in_valid && !in_ready) begin
        // hold the payload until it is taken
      end else if (drive_gap > 0 && !(in_valid && in_ready)) begin
        in_valid <= 1'b0;
        drive_gap <= drive_gap - 1;
      end else if (pending_items.size() > 0 && !(in_valid && in_ready && short_gap() > 0)) begin
        row_item_t it;
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_kind <= it.kind;
        in_row_index <= it.row_index;
        in_velocity <= it.velocity;
        in_mass <= it.mass;
        in_long_moi <= it.long_moi;
        in_radial_moi <= it.radial_moi;
        in_cg_pos <= it.cg_pos;
        in_cp_pos <= it.cp_pos;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // config write channel, driven only while idle
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        model_rows = cfg_rows_in_use;
        cfg_valid <= 1'b0;
        cfg_target <= -1;
      end else if (!cfg_valid && cfg_target >= 0) begin
        cfg_valid <= 1'b1;
        cfg_rows_in_use <= cfg_target[8:0];
      end
    end
  end

  // receiver ready: random stalls, or a long hold-off when requested
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= short_gap();
    end else out_ready <= 1'b1;
  end

  // monitor: compares each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      lookup_result_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        e = expected_results.pop_front();
        if (out_long_moi_out !== e.long_moi || out_radial_moi_out !== e.radial_moi ||
            out_cg_out !== e.cg || out_cp_out !== e.cp || out_table_empty !== e.empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                     e.long_moi, e.radial_moi, e.cg, e.cp, e.empty,
                     out_long_moi_out, out_radial_moi_out, out_cg_out, out_cp_out,
                     out_table_empty);
        end
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic row_item_t row_write(int idx, logic signed [31:0] v,
                                          logic signed [31:0] m);
    row_item_t it;
    it.kind = 1'b0;
    it.row_index = idx[7:0];
    it.velocity = v;
    it.mass = m;
    it.long_moi = $urandom();
    it.radial_moi = $urandom();
    it.cg_pos = $urandom();
    it.cp_pos = $urandom();
    return it;
  endfunction

  function automatic row_item_t query(logic signed [31:0] v, logic signed [31:0] m);
    row_item_t it;
    it = row_write(0, v, m);
    it.kind = 1'b1;
    it.row_index = 8'($urandom());
    return it;
  endfunction

  // load n ascending rows (random steps) starting from a random base
  task automatic load_table(int n, int step_max);
    int v, m;
    v = $urandom_range(0, 2000) - 1000;
    m = $urandom_range(0, 2000) - 1000;
    for (int i = 0; i < n; i++) begin
      enqueue(row_write(i, v, m));
      v += $urandom_range(1, step_max);
      m += $urandom_range(1, step_max);
    end
  endtask

  function automatic logic signed [31:0] key_near(int col);
    int unsigned n, i;
    n = (model_rows > 256) ? 256 : model_rows;
    if (n == 0 || $urandom_range(0, 9) == 0) return $urandom();
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 2))
      0: return model_table[i][col];
      1: return model_table[i][col] + $urandom_range(0, 3000) - 1500;
      default: return model_table[i][col] - $urandom_range(0, 3);
    endcase
  endfunction

  task automatic drain();
    wait (pending_items.size() == 0);
    @(posedge clk);
    while (in_valid || expected_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_rows(int n);
    cfg_target = n;
    @(posedge clk);
    while (cfg_target >= 0 || cfg_valid) @(posedge clk);
  endtask

  int sizes[] = '{1, 2, 0, 3, 8, 17, 40, 511};
  int qcount;
  initial begin
    model_rows = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, then a full 256-row table with extreme keys
    enqueue(query(32'sh7fffffff, 32'sh80000000));
    drain();
    for (int i = 0; i < 256; i++)
      enqueue(row_write(i, i * 1024 - 32'sd131072, i * 777 + 5));
    enqueue(row_write(255, 32'sh7fffffff, 32'sh7fffffff));
    enqueue(row_write(0, 32'sh80000000, 32'sh80000000));
    drain();
    set_rows(256);
    enqueue(query(32'sh80000000, 32'sh80000000));
    enqueue(query(32'sh7fffffff, 32'sh7fffffff));
    enqueue(query(32'sh00000000, 32'sh00000000));
    enqueue(query(32'sd5000, 32'sd6000));
    // unsorted keys: first match wins
    enqueue(row_write(10, 32'sd0, 32'sd0));
    enqueue(query(32'sd0, 32'sd1));
    drain();

    // long receiver hold-off while the sender keeps offering queries
    hold_off = 1'b1;
    for (int i = 0; i < 4; i++) enqueue(query($urandom(), $urandom()));
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
    drain();

    // random phases over several table sizes
    foreach (sizes[s]) begin
      int n;
      n = (sizes[s] > 256) ? 256 : sizes[s];
      if (n > 0) load_table(n, (s % 2) ? 70000 : 40);
      drain();
      set_rows(sizes[s]);
      qcount = (n > 64) ? 20 : 45;
      for (int q = 0; q < qcount; q++) begin
        if ($urandom_range(0, 9) == 0)
          enqueue(row_write($urandom_range(n, 255), $urandom(), $urandom()));
        enqueue(query(key_near(KVel), key_near(KMass)));
      end
      drain();
    end

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tli_pkg.sv
hw/rtl/tli_divider.sv
hw/rtl/tli_table_ram.sv
hw/rtl/table_linear_interpolator_top.sv
hw/rtl/tli_checker.sv
sim/tb_table_linear_interpolator_top.sv
